@@ rtl/lec_pkg.sv @@
// Package for the elevator sweep controller: result codes, register map,
// reset values and beat layouts. No dependencies.
`timescale 1ns / 1ps

package lec_pkg;

    localparam int FLOORS_DEF = 9;
    localparam int FLOOR_W    = 6;
    localparam int TICK_W     = 4;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [TICK_W-1:0] DOOR_TICKS_RST   = 4'd2;
    localparam logic [TICK_W-1:0] TRAVEL_TICKS_RST = 4'd1;

    typedef enum logic
    {
        CMD_REQUEST = 1'b0,
        CMD_TICK    = 1'b1
    } command_t;

    typedef enum logic
    {
        REG_DOOR_TICKS   = 1'b0,
        REG_TRAVEL_TICKS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        ST_ACCEPTED = 2'd0,
        ST_PENDING  = 2'd1,
        ST_INVALID  = 2'd2,
        ST_TICK     = 2'd3
    } status_t;

    typedef struct packed
    {
        logic               going_down;
        logic               served;
        logic [FLOOR_W-1:0] highest_target;
        logic [FLOOR_W-1:0] lowest_target;
        logic [FLOOR_W-1:0] current_floor;
        status_t            status;
    } result_t;

endpackage

@@ rtl/look_elevator_controller_core.sv @@
// Top level of the single-car elevator sweep controller.
// Depends on lec_pkg; checked by lec_checker (bound in its own file).
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one beat per event: s_tuser is the command
// (request or time tick) and s_tdata holds the floor number. Every beat
// yields exactly one result beat on the master stream, holding the status,
// the car position, the tracked lowest and highest targets, the served
// flag and the sweep direction after the event.
// A beat is captured in an input register and moves into the result
// register, which drives m_tvalid and m_tdata, once that register is free
// or its beat is being taken.
// One beat is accepted per cycle as long as results are taken.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more beat; then s_tready drops until the
// result moves on.
// The APB port sets door dwell (address 0) and travel time (address 4) in
// ticks; write it only while no beat is in flight.
// Reset clears all pending floors, parks the car at floor zero in the
// upward phase and loads the default dwell and travel times.
module look_elevator_controller_core #(
    parameter int FLOORS = lec_pkg::FLOORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [5:0] floor_number, [7:6] zero
    input  logic [lec_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] status, [7:2] current_floor, [13:8] lowest_target,
    // [19:14] highest_target, [20] served, [21] going_down, [23:22] zero
    output logic [lec_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lec_pkg::PADDR_W-1:0]  paddr,
    input  logic [lec_pkg::PDATA_W-1:0]  pwdata,
    output logic [lec_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int FW   = lec_pkg::FLOOR_W;
    localparam int TW   = lec_pkg::TICK_W;
    localparam int IDXW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam logic [FW:0] FLOORS_LIM = (FW + 1)'(FLOORS);

    logic [TW-1:0]     door_reg;
    logic [TW-1:0]     travel_reg;
    logic [FLOORS-1:0] pending_reg, pending_next;
    logic [FW-1:0]     car_reg, car_next;
    logic [FW-1:0]     low_reg, low_next;
    logic [FW-1:0]     high_reg, high_next;
    logic              sweep_reg, sweep_next;
    logic [TW-1:0]     wait_reg, wait_next;

    logic              in_valid_reg;
    lec_pkg::command_t cmd_reg;
    logic [FW-1:0]     floor_reg;

    logic              out_valid_reg;
    lec_pkg::result_t  out_reg, out_next;

    logic              advance;
    logic              cfg_write;

    function automatic logic in_range(input logic [FW-1:0] f);
        return {1'b0, f} < FLOORS_LIM;
    endfunction

    function automatic logic pend_at(input logic [FLOORS-1:0] vec,
                                     input logic [FW-1:0] f);
        logic [IDXW-1:0] idx;
        idx = IDXW'(f);
        return in_range(f) && vec[idx];
    endfunction

    function automatic logic [FLOORS-1:0] put_bit(input logic [FLOORS-1:0] vec,
                                                  input logic [FW-1:0] f,
                                                  input logic v);
        logic [FLOORS-1:0] res;
        logic [IDXW-1:0]   idx;
        res = vec;
        idx = IDXW'(f);
        if (in_range(f))
        begin
            res[idx] = v;
        end
        return res;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (lec_pkg::reg_index_t'(paddr[2]))
            lec_pkg::REG_DOOR_TICKS:   prdata = {{(lec_pkg::PDATA_W - TW){1'b0}}, door_reg};
            lec_pkg::REG_TRAVEL_TICKS: prdata = {{(lec_pkg::PDATA_W - TW){1'b0}}, travel_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_reg   <= lec_pkg::DOOR_TICKS_RST;
            travel_reg <= lec_pkg::TRAVEL_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (lec_pkg::reg_index_t'(paddr[2]))
                lec_pkg::REG_DOOR_TICKS:   door_reg   <= pwdata[TW-1:0];
                lec_pkg::REG_TRAVEL_TICKS: travel_reg <= pwdata[TW-1:0];
                default:                   ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lec_pkg::M_TDATA_W - $bits(lec_pkg::result_t)){1'b0}}, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= lec_pkg::command_t'(s_tuser);
            floor_reg <= s_tdata[FW-1:0];
        end
    end

    always_comb
    begin
        logic             upc;
        logic             dnc;
        logic             do_up;
        logic             do_down;
        logic             served;
        logic [TW-1:0]    travel_wait;
        lec_pkg::status_t status;

        pending_next = pending_reg;
        car_next     = car_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        sweep_next   = sweep_reg;
        wait_next    = wait_reg;
        served       = 1'b0;
        status       = lec_pkg::ST_TICK;
        do_up        = 1'b0;
        do_down      = 1'b0;
        travel_wait  = (travel_reg == '0) ? '0 : travel_reg - TW'(1);

        upc = pend_at(pending_reg, high_reg) && (high_reg >= car_reg);
        dnc = pend_at(pending_reg, low_reg) && (low_reg <= car_reg);

        if (cmd_reg == lec_pkg::CMD_TICK)
        begin
            if (wait_reg != '0)
            begin
                wait_next = wait_reg - TW'(1);
            end
            else if (!sweep_reg)
            begin
                if (upc)
                begin
                    do_up = 1'b1;
                end
                else if (dnc)
                begin
                    sweep_next = 1'b1;
                    do_down    = 1'b1;
                end
            end
            else
            begin
                if (dnc)
                begin
                    do_down = 1'b1;
                end
                else
                begin
                    sweep_next = 1'b0;
                    do_up      = upc;
                end
            end

            if (do_up)
            begin
                if (car_reg == high_reg)
                begin
                    pending_next = put_bit(pending_reg, car_reg, 1'b0);
                    sweep_next   = 1'b1;
                    served       = 1'b1;
                end
                else if (pend_at(pending_reg, car_reg))
                begin
                    pending_next = put_bit(pending_reg, car_reg, 1'b0);
                    wait_next    = door_reg;
                    served       = 1'b1;
                end
                else
                begin
                    car_next  = car_reg + FW'(1);
                    wait_next = travel_wait;
                end
            end
            else if (do_down)
            begin
                if (car_reg == low_reg)
                begin
                    pending_next = put_bit(pending_reg, car_reg, 1'b0);
                    sweep_next   = 1'b0;
                    served       = 1'b1;
                end
                else if (pend_at(pending_reg, car_reg))
                begin
                    pending_next = put_bit(pending_reg, car_reg, 1'b0);
                    wait_next    = door_reg;
                    served       = 1'b1;
                end
                else
                begin
                    car_next  = car_reg - FW'(1);
                    wait_next = travel_wait;
                end
            end
        end
        else if (!in_range(floor_reg))
        begin
            status = lec_pkg::ST_INVALID;
        end
        else if (pend_at(pending_reg, floor_reg))
        begin
            status = lec_pkg::ST_PENDING;
        end
        else
        begin
            status       = lec_pkg::ST_ACCEPTED;
            pending_next = put_bit(pending_reg, floor_reg, 1'b1);
            // The two target updates chain: the second sees the first's result.
            if ((floor_reg < low_reg) || !pend_at(pending_next, low_reg))
            begin
                if (!pend_at(pending_next, high_reg))
                begin
                    high_next = low_reg;
                end
                low_next = floor_reg;
            end
            if ((floor_reg > high_next) || !pend_at(pending_next, high_next))
            begin
                if (!pend_at(pending_next, low_next))
                begin
                    low_next = high_next;
                end
                high_next = floor_reg;
            end
        end

        out_next.status         = status;
        out_next.current_floor  = car_next;
        out_next.lowest_target  = low_next;
        out_next.highest_target = high_next;
        out_next.served         = served;
        out_next.going_down     = sweep_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            car_reg     <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            sweep_reg   <= 1'b0;
            wait_reg    <= '0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            car_reg     <= car_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            sweep_reg   <= sweep_next;
            wait_reg    <= wait_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/lec_checker.sv @@
// Port-level checks for look_elevator_controller_core, with the bind that
// attaches them. Depends on lec_pkg.
`timescale 1ns / 1ps

module lec_checker #(
    parameter int FLOORS = lec_pkg::FLOORS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lec_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int FW = lec_pkg::FLOOR_W;
    localparam logic [FW:0] FLOORS_LIM = (FW + 1)'(FLOORS);

    lec_pkg::result_t res;
    assign res = lec_pkg::result_t'(m_tdata[$bits(lec_pkg::result_t)-1:0]);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result beat changed while stalled.");

    a_served_tick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.served |-> res.status == lec_pkg::ST_TICK)
        else $error("Served flag set on a request result.");

    a_in_building: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> {1'b0, res.current_floor} < FLOORS_LIM
                  && {1'b0, res.lowest_target} < FLOORS_LIM
                  && {1'b0, res.highest_target} < FLOORS_LIM)
        else $error("Car or target outside the building.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("Input stalled without a stalled result.");

endmodule

bind look_elevator_controller_core lec_checker #(.FLOORS(FLOORS)) u_lec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/look_elevator_controller_core_tb.sv @@
// Testbench for look_elevator_controller_core: drives request and tick beats,
// predicts every result beat and checks it field by field. Needs lec_pkg.
`timescale 1ns / 1ps

module look_elevator_controller_core_tb;
    import lec_pkg::*;

    localparam int FLOORS      = FLOORS_DEF;
    localparam int RES_W       = $bits(result_t);
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    look_elevator_controller_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [FLOORS-1:0] pend_q   = '0;
    logic [5:0]        car_q    = '0;
    logic [5:0]        low_q    = '0;
    logic [5:0]        high_q   = '0;
    logic              down_q   = 1'b0;
    logic [3:0]        wait_q   = '0;
    logic [3:0]        door_q   = DOOR_TICKS_RST;
    logic [3:0]        travel_q = TRAVEL_TICKS_RST;

    result_t results_due[$];
    int      src_idle_pct  = 0;
    int      sink_idle_pct = 0;
    int      error_count   = 0;
    int      checked_count = 0;
    int      request_count = 0;
    int      tick_count    = 0;
    int      served_count  = 0;
    int      cycle_count   = 0;

    function automatic logic floor_pending(input logic [5:0] f);
        return (f < FLOORS) ? pend_q[f] : 1'b0;
    endfunction

    function automatic void set_floor(input logic [5:0] f, input logic v);
        if (f < FLOORS)
            pend_q[f] = v;
    endfunction

    function automatic void start_travel();
        wait_q = (travel_q == 4'd0) ? 4'd0 : travel_q - 4'd1;
    endfunction

    function automatic logic step_up();
        if (car_q == high_q)
        begin
            set_floor(car_q, 1'b0);
            down_q = 1'b1;
            return 1'b1;
        end
        if (floor_pending(car_q))
        begin
            set_floor(car_q, 1'b0);
            wait_q = door_q;
            return 1'b1;
        end
        car_q = car_q + 6'd1;
        start_travel();
        return 1'b0;
    endfunction

    function automatic logic step_down();
        if (car_q == low_q)
        begin
            set_floor(car_q, 1'b0);
            down_q = 1'b0;
            return 1'b1;
        end
        if (floor_pending(car_q))
        begin
            set_floor(car_q, 1'b0);
            wait_q = door_q;
            return 1'b1;
        end
        car_q = car_q - 6'd1;
        start_travel();
        return 1'b0;
    endfunction

    function automatic result_t car_after_beat(input command_t cmd, input logic [5:0] fl);
        result_t r;
        logic    served;
        logic    up_work;
        logic    down_work;
        served = 1'b0;
        if (cmd == CMD_TICK)
        begin
            r.status = ST_TICK;
            if (wait_q != 4'd0)
                wait_q = wait_q - 4'd1;
            else
            begin
                up_work   = floor_pending(high_q) && (high_q >= car_q);
                down_work = floor_pending(low_q) && (low_q <= car_q);
                if (!down_q)
                begin
                    if (up_work)
                        served = step_up();
                    else if (down_work)
                    begin
                        down_q = 1'b1;
                        served = step_down();
                    end
                end
                else if (down_work)
                    served = step_down();
                else
                begin
                    down_q = 1'b0;
                    if (up_work)
                        served = step_up();
                end
            end
        end
        else if (fl >= FLOORS)
            r.status = ST_INVALID;
        else if (floor_pending(fl))
            r.status = ST_PENDING;
        else
        begin
            r.status = ST_ACCEPTED;
            set_floor(fl, 1'b1);
            if ((fl < low_q) || !floor_pending(low_q))
            begin
                if (!floor_pending(high_q))
                    high_q = low_q;
                low_q = fl;
            end
            if ((fl > high_q) || !floor_pending(high_q))
            begin
                if (!floor_pending(low_q))
                    low_q = high_q;
                high_q = fl;
            end
        end
        r.current_floor  = car_q;
        r.lowest_target  = low_q;
        r.highest_target = high_q;
        r.served         = served;
        r.going_down     = down_q;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("ERROR at %0t: result %0d, %s expected %0d got %0d",
                 $realtime, checked_count, field, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RES_W-1:0];
            if (results_due.size() == 0)
                report_mismatch("unexpected beat, status", 0, got.status);
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.current_floor !== want.current_floor)
                    report_mismatch("current_floor", want.current_floor, got.current_floor);
                if (got.lowest_target !== want.lowest_target)
                    report_mismatch("lowest_target", want.lowest_target, got.lowest_target);
                if (got.highest_target !== want.highest_target)
                    report_mismatch("highest_target", want.highest_target, got.highest_target);
                if (got.served !== want.served)
                    report_mismatch("served", want.served, got.served);
                if (got.going_down !== want.going_down)
                    report_mismatch("going_down", want.going_down, got.going_down);
                if (m_tdata[M_TDATA_W-1:RES_W] !== '0)
                    report_mismatch("padding", 0, m_tdata[M_TDATA_W-1:RES_W]);
            end
            checked_count++;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(input command_t cmd, input logic [5:0] fl);
        result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, fl};
        do
            @(posedge clk);
        while (!s_tready);
        r = car_after_beat(cmd, fl);
        results_due.push_back(r);
        if (cmd == CMD_TICK)
            tick_count++;
        else
            request_count++;
        if (r.served)
            served_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {28'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_DOOR_TICKS)
            door_q = value;
        else
            travel_q = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [3:0] door, input logic [3:0] travel);
        drain();
        write_register(REG_DOOR_TICKS, door);
        write_register(REG_TRAVEL_TICKS, travel);
    endtask

    task automatic run_traffic(input int n_beats);
        command_t    cmd;
        logic [5:0]  fl;
        for (int k = 0; k < n_beats; k++)
        begin
            cmd = ($urandom_range(99) < 55) ? CMD_TICK : CMD_REQUEST;
            if ($urandom_range(9) == 0)
                fl = 6'($urandom_range(63));
            else
                fl = 6'($urandom_range(FLOORS - 1));
            send_beat(cmd, fl);
        end
    endtask

    task automatic test_directed();
        set_timing(DOOR_TICKS_RST, TRAVEL_TICKS_RST);
        send_beat(CMD_TICK, 6'd0);
        send_beat(CMD_REQUEST, 6'd0);
        send_beat(CMD_REQUEST, 6'd0);
        send_beat(CMD_REQUEST, 6'(FLOORS - 1));
        send_beat(CMD_REQUEST, 6'(FLOORS));
        send_beat(CMD_REQUEST, 6'd63);
        send_beat(CMD_REQUEST, 6'd4);
        for (int k = 0; k < 9; k++)
            send_beat(CMD_TICK, 6'(k * 7));
        send_beat(CMD_REQUEST, 6'd1);
        send_beat(CMD_REQUEST, 6'd5);
        for (int k = 0; k < 7; k++)
            send_beat(CMD_TICK, 6'd63);
    endtask

    task automatic test_sweep_defaults();
        set_timing(4'd2, 4'd1);
        run_traffic(420);
    endtask

    task automatic test_slow_car();
        set_timing(4'd15, 4'd15);
        run_traffic(300);
    endtask

    task automatic test_zero_travel();
        set_timing(4'd0, 4'd0);
        run_traffic(200);
    endtask

    task automatic test_random_timing();
        for (int k = 0; k < 4; k++)
        begin
            set_timing(4'($urandom_range(15)), 4'($urandom_range(15)));
            run_traffic(100);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 28;
        sink_idle_pct = 62;
        test_directed();
        test_sweep_defaults();

        src_idle_pct  = 62;
        sink_idle_pct = 28;
        test_slow_car();
        test_zero_travel();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_timing();

        drain();
        repeat (8) @(posedge clk);

        $display("Checked %0d result beats from %0d requests and %0d ticks;",
                 checked_count, request_count, tick_count);
        $display("%0d floors served across several dwell and travel settings.",
                 served_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
